[sv/mtfe_pkg.sv]
// Shared types and constants for the move-to-front tile pair encoder.
// No dependencies; imported by every module of the block.
package mtfe_pkg;

   localparam int TILE_W          = 11;
   localparam int CODE_W          = 12;
   localparam int LEN_W           = 4;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ITEM_DEPTH      = 2;
   localparam int RSP_DEPTH       = 4;

   localparam logic [CODE_W-1:0] HIT_MARK = CODE_W'(16);
   localparam logic [LEN_W-1:0]  HIT_LEN  = LEN_W'(5);
   localparam logic [LEN_W-1:0]  LIT_LEN  = LEN_W'(12);
   localparam logic [LEN_W-1:0]  FLAG_LEN = LEN_W'(1);

   // classified pair waiting for the back end
   typedef struct packed {
      logic              first_of_set;
      logic [TILE_W-1:0] left_tile;
      logic [TILE_W-1:0] right_tile;
      logic              match;
   } item_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_length;
      logic              last_of_pair;
   } rsp_type;

   // up to two code words written per cycle
   typedef struct packed {
      logic    en0;
      logic    en1;
      rsp_type d0;
      rsp_type d1;
   } rsp_wr_type;

endpackage

[sv/mtfe_front.sv]
// Front end: accepts tile pairs, computes the right-tile prediction match,
// and holds classified pairs in a two-entry queue. Uses mtfe_pkg.
module mtfe_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic                           req_first_of_set,
   input  logic [mtfe_pkg::TILE_W-1:0]    req_left_tile,
   input  logic                           req_left_hflip,
   input  logic [mtfe_pkg::TILE_W-1:0]    req_right_tile,
   output logic                           item_valid,
   output mtfe_pkg::item_type             item,
   input  logic                           item_pop
);
   import mtfe_pkg::*;

   localparam int PW = $clog2(ITEM_DEPTH);

   item_type          mem [ITEM_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;
   logic              wr_ok;
   logic              match;
   item_type          wr_item;

   always_comb begin
      // compare in one extra bit so left+1 never wraps
      if (req_left_hflip) begin
         match = (req_left_tile != '0) &&
                 (req_right_tile == req_left_tile - TILE_W'(1));
      end else begin
         match = ({1'b0, req_right_tile} == ({1'b0, req_left_tile} + (TILE_W+1)'(1)));
      end
      wr_item.first_of_set = req_first_of_set;
      wr_item.left_tile    = req_left_tile;
      wr_item.right_tile   = req_right_tile;
      wr_item.match        = match;
   end

   assign full       = (count_ff == (PW+1)'(ITEM_DEPTH));
   assign wr_ok      = push && !full;
   assign item_valid = (count_ff != '0);
   assign item       = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ok ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = item_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(wr_ok) - (PW+1)'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/mtfe_back.sv]
// Back end: move-to-front queue with one compare-and-shift per cycle while the result
// queue has room, and a two-phase sequencer (left tile, then right tile unless predicted). Uses mtfe_pkg.
module mtfe_back #(
   parameter int QUEUE_DEPTH = mtfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  mtfe_pkg::item_type   item,
   output logic                 item_pop,
   input  logic                 room1,
   input  logic                 room2,
   output mtfe_pkg::rsp_wr_type wr
);
   import mtfe_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic PH_LEFT  = 1'b0;
   localparam logic PH_RIGHT = 1'b1;

   logic [TILE_W-1:0] tiles_ff [QUEUE_DEPTH];
   logic [TILE_W-1:0] tiles_in [QUEUE_DEPTH];
   logic [TILE_W-1:0] base     [QUEUE_DEPTH];
   logic              phase_ff, phase_in;
   logic [TILE_W-1:0] tile;
   logic              hit;
   logic [PW-1:0]     pos;
   logic [PW-1:0]     last_pos;
   logic              go;
   logic [CODE_W-1:0] code;

   always_comb begin
      tile = (phase_ff == PH_RIGHT) ? item.right_tile : item.left_tile;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         base[i] = (phase_ff == PH_LEFT && item.first_of_set) ? '0 : tiles_ff[i];
      end
      // lowest matching entry wins
      hit = 1'b0;
      pos = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (base[i] == tile) begin
            hit = 1'b1;
            pos = PW'(i);
         end
      end
      // a miss shifts the whole queue, dropping the last entry
      last_pos = hit ? pos : PW'(QUEUE_DEPTH - 1);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (i == 0) begin
            tiles_in[i] = tile;
         end else if (PW'(i) <= last_pos) begin
            tiles_in[i] = base[i-1];
         end else begin
            tiles_in[i] = base[i];
         end
      end
      code = hit ? (HIT_MARK + CODE_W'(pos)) : {1'b0, tile};
   end

   always_comb begin
      go = item_valid && ((phase_ff == PH_LEFT) ? room2 : room1);

      wr.en0            = go;
      wr.d0.code_bits    = code;
      wr.d0.code_length  = hit ? HIT_LEN : LIT_LEN;
      wr.d0.last_of_pair = (phase_ff == PH_RIGHT);

      wr.en1            = go && (phase_ff == PH_LEFT);
      wr.d1.code_bits    = CODE_W'(item.match);
      wr.d1.code_length  = FLAG_LEN;
      wr.d1.last_of_pair = item.match;

      item_pop = go && ((phase_ff == PH_RIGHT) || item.match);

      phase_in = phase_ff;
      if (go) begin
         phase_in = (phase_ff == PH_LEFT && !item.match) ? PH_RIGHT : PH_LEFT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEFT;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            tiles_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         if (go) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
               tiles_ff[i] <= tiles_in[i];
            end
         end
      end
   end

endmodule

[sv/mtfe_rsp_fifo.sv]
// Result queue: four code words, up to two written and one read per cycle.
// Uses mtfe_pkg.
module mtfe_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  mtfe_pkg::rsp_wr_type              wr,
   output logic                              room1,
   output logic                              room2,
   output logic                              empty,
   input  logic                              pop,
   output logic [mtfe_pkg::CODE_W-1:0]       rsp_code_bits,
   output logic [mtfe_pkg::LEN_W-1:0]        rsp_code_length,
   output logic                              rsp_last_of_pair
);
   import mtfe_pkg::*;

   localparam int PW = $clog2(RSP_DEPTH);

   rsp_type       mem [RSP_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          rd_ok;
   rsp_type       head;

   assign empty = (count_ff == '0);
   assign room1 = (count_ff <= (PW+1)'(RSP_DEPTH - 1));
   assign room2 = (count_ff <= (PW+1)'(RSP_DEPTH - 2));
   assign rd_ok = pop && !empty;
   assign head  = mem[rd_ptr_ff];

   assign rsp_code_bits    = head.code_bits;
   assign rsp_code_length  = head.code_length;
   assign rsp_last_of_pair = head.last_of_pair;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(wr.en0) + PW'(wr.en1);
      rd_ptr_in = rd_ok ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(wr.en0) + (PW+1)'(wr.en1) - (PW+1)'(rd_ok);
   end

   always_ff @(posedge clock) begin
      if (wr.en0) begin
         mem[wr_ptr_ff] <= wr.d0;
      end
      if (wr.en1) begin
         mem[wr_ptr_ff + PW'(1)] <= wr.d1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/mtf_tile_pair_encoder_unit.sv]
// Move-to-front tile pair encoder, top level. Depends on mtfe_pkg, mtfe_front,
// mtfe_back and mtfe_rsp_fifo.
// Each pair gives two code words when the right tile is predicted, else three; the
// result port hands out one word per cycle while pop is held, and the pair queue can
// take a new pair while the back end is still working on an earlier one.
// Reset: recent-tile queue all zeros, pair and result queues empty.
module mtf_tile_pair_encoder_unit #(
   parameter int QUEUE_DEPTH = mtfe_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic                         req_first_of_set,
   input  logic [mtfe_pkg::TILE_W-1:0]  req_left_tile,
   input  logic                         req_left_hflip,
   input  logic [mtfe_pkg::TILE_W-1:0]  req_right_tile,
   output logic                         empty,
   input  logic                         pop,
   output logic [mtfe_pkg::CODE_W-1:0]  rsp_code_bits,
   output logic [mtfe_pkg::LEN_W-1:0]   rsp_code_length,
   output logic                         rsp_last_of_pair
);
   import mtfe_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       item_pop;
   logic       room1;
   logic       room2;
   rsp_wr_type wr;

   mtfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_first_of_set (req_first_of_set),
      .req_left_tile    (req_left_tile),
      .req_left_hflip   (req_left_hflip),
      .req_right_tile   (req_right_tile),
      .item_valid       (item_valid),
      .item             (item),
      .item_pop         (item_pop)
   );

   mtfe_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .room1      (room1),
      .room2      (room2),
      .wr         (wr)
   );

   mtfe_rsp_fifo u_rsp_fifo (
      .clock            (clock),
      .reset            (reset),
      .wr               (wr),
      .room1            (room1),
      .room2            (room2),
      .empty            (empty),
      .pop              (pop),
      .rsp_code_bits    (rsp_code_bits),
      .rsp_code_length  (rsp_code_length),
      .rsp_last_of_pair (rsp_last_of_pair)
   );

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("back end retired a pair with none pending");

   a_flag_with_left: assert property (@(posedge clock) disable iff (reset)
      wr.en1 |-> wr.en0)
      else $error("flag word written without its left code");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> ((wr.en1 && wr.d1.last_of_pair) ||
                    (wr.en0 && !wr.en1 && wr.d0.last_of_pair)))
      else $error("pair retired without a final code word");

endmodule

[bench/testbench.sv]
// Self-checking bench for mtf_tile_pair_encoder_unit: a directed table, then random pairs.
// Every popped word is checked against a row's typed words, or else an in-bench move-to-front predictor.
// Depends on mtfe_pkg and the encoder RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mtfe_pkg::*;

   localparam int NUM_RANDOM   = 340;
   localparam int QUIET_ITEMS  = 60;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 80;
   localparam int POOL_SIZE    = 24;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 100000;

   typedef struct {
      logic              first;
      logic [TILE_W-1:0] left;
      logic              hflip;
      logic [TILE_W-1:0] right;
      int                n_typed;
      rsp_type [2:0]     typed;
   } pair_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic req_first_of_set = 1'b0;
   logic [TILE_W-1:0] req_left_tile = '0;
   logic req_left_hflip = 1'b0;
   logic [TILE_W-1:0] req_right_tile = '0;
   logic empty;
   logic pop = 1'b0;
   logic [CODE_W-1:0] rsp_code_bits;
   logic [LEN_W-1:0] rsp_code_length;
   logic rsp_last_of_pair;

   logic [TILE_W-1:0] mru_tiles [QUEUE_DEPTH_DEF];
   logic [TILE_W-1:0] tile_pool [POOL_SIZE];
   rsp_type pair_words [$];
   rsp_type pending_words [$];
   pair_row_type stim_table [$];

   int errors = 0;
   int cycles = 0;
   bit quiet_tail = 0;
   bit backpressure_req = 0;
   bit backpressure_on = 0;

   mtf_tile_pair_encoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_first_of_set (req_first_of_set),
      .req_left_tile    (req_left_tile),
      .req_left_hflip   (req_left_hflip),
      .req_right_tile   (req_right_tile),
      .empty            (empty),
      .pop              (pop),
      .rsp_code_bits    (rsp_code_bits),
      .rsp_code_length  (rsp_code_length),
      .rsp_last_of_pair (rsp_last_of_pair)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic rsp_type word(input int bits, input int len, input logic last);
      rsp_type w;
      w.code_bits    = bits[CODE_W-1:0];
      w.code_length  = len[LEN_W-1:0];
      w.last_of_pair = last;
      return w;
   endfunction

   task automatic add_row(input logic f, input int l, input logic h, input int r,
                          input int n = 0, input rsp_type w0 = '0,
                          input rsp_type w1 = '0, input rsp_type w2 = '0);
      pair_row_type row;
      row.first   = f;
      row.left    = l[TILE_W-1:0];
      row.hflip   = h;
      row.right   = r[TILE_W-1:0];
      row.n_typed = n;
      row.typed   = {w2, w1, w0};
      stim_table  = {stim_table, row};
   endtask

   // look up one tile, move it (or push it) to the front, return its code word
   function automatic rsp_type code_tile(input logic [TILE_W-1:0] tile, input logic last);
      int pos;
      int i;
      rsp_type w;
      pos = -1;
      for (i = 0; i < QUEUE_DEPTH_DEF; i++)
         if (pos < 0 && mru_tiles[i] == tile) pos = i;
      for (i = (pos < 0) ? QUEUE_DEPTH_DEF - 1 : pos; i > 0; i--)
         mru_tiles[i] = mru_tiles[i-1];
      mru_tiles[0] = tile;
      if (pos < 0) begin
         w.code_bits   = {1'b0, tile};
         w.code_length = LIT_LEN;
      end else begin
         w.code_bits   = HIT_MARK + CODE_W'(pos);
         w.code_length = HIT_LEN;
      end
      w.last_of_pair = last;
      return w;
   endfunction

   task automatic encode_pair(input pair_row_type row);
      int li;
      int ri;
      bit match;
      li = int'(row.left);
      ri = int'(row.right);
      pair_words.delete();
      if (row.first)
         foreach (mru_tiles[i]) mru_tiles[i] = '0;
      pair_words = {pair_words, code_tile(row.left, 1'b0)};
      // integer compare: left 0 flipped and left 2047 unflipped never match
      match = row.hflip ? (ri == li - 1) : (ri == li + 1);
      if (match) begin
         pair_words = {pair_words, word(1, FLAG_LEN, 1'b1)};
      end else begin
         pair_words = {pair_words, word(0, FLAG_LEN, 1'b0)};
         pair_words = {pair_words, code_tile(row.right, 1'b1)};
      end
   endtask

   task automatic flag_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      errors++;
   endtask

   task automatic check_word(input rsp_type got);
      rsp_type exp;
      if (pending_words.size() == 0) begin
         flag_mismatch($sformatf("unexpected word bits=%0d len=%0d last=%0b",
                                 got.code_bits, got.code_length, got.last_of_pair));
      end else begin
         exp = pending_words.pop_front();
         if (got.code_bits !== exp.code_bits || got.code_length !== exp.code_length ||
             got.last_of_pair !== exp.last_of_pair)
            flag_mismatch($sformatf("bits=%0d/%0d len=%0d/%0d last=%0b/%0b (got/exp)",
                                    got.code_bits, exp.code_bits, got.code_length,
                                    exp.code_length, got.last_of_pair, exp.last_of_pair));
      end
   endtask

   initial begin : sender
      pair_row_type row;
      int total;
      int idx;
      int k;
      int sel;
      bit taken;

      foreach (mru_tiles[i]) mru_tiles[i] = '0;
      foreach (tile_pool[i]) tile_pool[i] = TILE_W'($urandom_range(0, 2047));
      tile_pool[0] = '0;
      tile_pool[1] = '1;

      // after reset the queue is all zeros, so tile 0 hits the front
      add_row(0, 0, 0, 1, 2, word(16, 5, 0), word(1, 1, 1));
      // flipped tile 0 predicts below range
      add_row(0, 0, 1, 2047, 3, word(16, 5, 0), word(0, 1, 0), word(2047, 12, 1));
      // unflipped 2047 predicts above range; right tile 0 now sits at position 1
      add_row(0, 2047, 0, 0, 3, word(16, 5, 0), word(0, 1, 0), word(17, 5, 1));
      add_row(1, 2047, 1, 2046, 2, word(2047, 12, 0), word(1, 1, 1));
      // cleared queue full of duplicate zeros: lowest position hits
      add_row(1, 0, 1, 0, 3, word(16, 5, 0), word(0, 1, 0), word(16, 5, 1));
      add_row(0, 1365, 0, 682);
      add_row(0, 682, 1, 1365);
      for (k = 1; k <= 7; k++)
         add_row(0, 100 * k, k[0], 100 * k + 50);
      // both tiles at the last position, then a miss that drops the last entry
      add_row(0, 682, 0, 1365);
      add_row(0, 0, 0, 5);
      add_row(0, 5, 0, 6);
      add_row(0, 6, 1, 5);
      add_row(0, 1024, 0, 1024);
      add_row(0, 1023, 1, 1022);

      total = stim_table.size() + NUM_RANDOM;
      while (reset) @(posedge clock);

      for (idx = 0; idx < total; idx++) begin
         if (idx < stim_table.size()) begin
            row = stim_table[idx];
         end else begin
            row.n_typed = 0;
            row.first   = ($urandom_range(0, 29) == 0);
            row.left    = ($urandom_range(0, 3) != 0) ? tile_pool[$urandom_range(0, POOL_SIZE-1)]
                                                      : TILE_W'($urandom_range(0, 2047));
            row.hflip   = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 99);
            if (sel < 40 && !(row.hflip && row.left == 0))
               row.right = row.hflip ? row.left - 1'b1 : row.left + 1'b1;
            else if (sel < 85)
               row.right = tile_pool[$urandom_range(0, POOL_SIZE-1)];
            else
               row.right = TILE_W'($urandom_range(0, 2047));
         end
         quiet_tail = (idx >= total - QUIET_ITEMS);
         if (idx == HOLD_AT) backpressure_req = 1;

         if (!quiet_tail && !backpressure_on && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         push             <= 1'b1;
         req_first_of_set <= row.first;
         req_left_tile    <= row.left;
         req_left_hflip   <= row.hflip;
         req_right_tile   <= row.right;

         // full is sampled mid-cycle; a low full means the pair goes in at the next edge
         do begin
            @(negedge clock);
            taken = !full;
            if (taken) begin
               encode_pair(row);
               if (row.n_typed > 0)
                  for (k = 0; k < row.n_typed; k++)
                     pending_words = {pending_words, row.typed[k]};
               else
                  foreach (pair_words[i]) pending_words = {pending_words, pair_words[i]};
            end
            @(posedge clock);
         end while (!taken);
      end
      push <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin : receiver
      int stall;
      int hold_left;
      bit hold_done;
      bit p;
      bit seen_empty;
      rsp_type got;

      stall = 0;
      hold_left = 0;
      hold_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (backpressure_req && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
         end
         backpressure_on = (hold_left > 0);
         if (hold_left > 0) begin
            p = 0;
            hold_left--;
         end else if (stall > 0) begin
            p = 0;
            stall--;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            p = 0;
            stall = $urandom_range(1, 8) - 1;
         end else begin
            p = 1;
         end
         pop <= p;
         @(negedge clock);
         seen_empty       = empty;
         got.code_bits    = rsp_code_bits;
         got.code_length  = rsp_code_length;
         got.last_of_pair = rsp_last_of_pair;
         @(posedge clock);
         if (p && !seen_empty) check_word(got);
      end
   end

endmodule
